### hw/rtl/bba_pkg.sv
// bba_pkg: shared types and constants of the bitmap block allocator
// used by bba_front, bba_engine and bitmap_block_allocator

package bba_pkg;

	localparam int NumBlocks = 4096;
	localparam int WordBits = 32;
	localparam int NumWords = NumBlocks / WordBits;
	localparam int IdxW = $clog2(NumBlocks);
	localparam int CntW = IdxW + 1;
	localparam int WordAw = $clog2(NumWords);
	localparam int BitAw = $clog2(WordBits);
	localparam int QDepth = 2;

	typedef enum logic [1:0] {
		ACT_ALLOC   = 2'd0,
		ACT_RELEASE = 2'd1,
		ACT_RESERVE = 2'd2,
		ACT_NONE    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		FIT_FIRST = 2'd0,
		FIT_NEXT  = 2'd1,
		FIT_BEST  = 2'd2,
		FIT_WORST = 2'd3
	} fit_t;

	localparam logic CFG_FIT = 1'b0;
	localparam logic CFG_COUNT = 1'b1;

	// classified command handed from front to engine
	typedef struct packed {
		logic              bad;
		action_t           action;
		logic [IdxW-1:0]   start;
		logic [CntW-1:0]   len;
	} cmd_t;

endpackage

### hw/rtl/bitmap_block_allocator.sv
// bitmap_block_allocator: allocates, releases and reserves runs of blocks
// in a used/free bitmap of 4096 blocks; after reset every block is used.
// Items enter on s_axis (tdata: action[1:0], run_start[13:2],
// run_length[26:14]); each gives one result on m_axis (tdata: success[0],
// granted_start[12:1]). A front stage checks count and range and queues two
// commands; the engine works one at a time.
// Release or reserve: one read and one write per touched 32-bit word.
// Allocation: one block scanned per cycle, plus one memory read per word
// (next fit first takes its pointer modulo block_count), then marking.
// Reset clears control state only; words never written read as all used,
// so no clearing pass is needed. A stalled m_axis holds the result and
// the engine; the front queue keeps taking items until full.
// Config: cfg_we with cfg_index 0 fit_strategy, 1 block_count, only when idle;
// the block does not enforce this. depends on bba_pkg, bba_front, bba_engine

module bitmap_block_allocator
	import bba_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // action, run_start, run_length
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // success, granted_start
);

	fit_t fit_q;
	logic [CntW-1:0] count_q;
	logic [CntW-1:0] total;
	logic cmd_valid, cmd_ready;
	cmd_t cmd;
	logic ok;
	logic [IdxW-1:0] gst;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_q <= FIT_FIRST;
			count_q <= CntW'(NumBlocks);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FIT: fit_q <= fit_t'(cfg_data[1:0]);
				CFG_COUNT: count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign total = (count_q > CntW'(NumBlocks)) ? CntW'(NumBlocks) : count_q;

	bba_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_action(s_axis_tdata[1:0]), .in_start(s_axis_tdata[13:2]),
		.in_len(s_axis_tdata[26:14]), .total,
		.cmd_valid, .cmd_ready, .cmd
	);

	bba_engine u_engine (
		.clk, .arst_n, .cmd_valid, .cmd_ready, .cmd, .total, .fit(fit_q),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
		.res_ok(ok), .res_start(gst)
	);

	assign m_axis_tdata = {3'b0, gst, ok};

endmodule

### hw/rtl/bba_front.sv
// bba_front: accepts input items, checks range and count, queues commands
// depends on bba_pkg

module bba_front
	import bba_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [1:0]      in_action,
	input  logic [IdxW-1:0] in_start,
	input  logic [CntW-1:0] in_len,
	input  logic [CntW-1:0] total,
	output logic            cmd_valid,
	input  logic            cmd_ready,
	output cmd_t            cmd
);

	cmd_t q_mem_q [QDepth];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	cmd_t c;
	logic [CntW:0] endp;

	always_comb begin
		endp = {1'b0, in_len} + {{(CntW-IdxW+1){1'b0}}, in_start};
		c.action = action_t'(in_action);
		c.start = in_start;
		c.len = in_len;
		c.bad = (in_len == '0) || (total == '0);
		case (c.action) inside
			ACT_ALLOC: if (in_len > total) c.bad = 1'b1;
			ACT_RELEASE, ACT_RESERVE: if (endp > {1'b0, total}) c.bad = 1'b1;
			default: c.bad = 1'b1;
		endcase
	end

	assign in_ready = (cnt_q != 2'(QDepth));
	assign cmd_valid = (cnt_q != '0);
	assign cmd = q_mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) q_mem_q[wp_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (in_valid && in_ready) wp_q <= ~wp_q;
			if (cmd_valid && cmd_ready) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(in_valid && in_ready) - 2'(cmd_valid && cmd_ready);
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'(QDepth)) else $error("queue overflow");
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'(QDepth)) |-> !in_ready) else $error("ready while full");
	a_empty_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> !cmd_valid) else $error("valid while empty");
`endif

endmodule

### hw/rtl/bba_engine.sv
// bba_engine: bitmap memory, clearing-free init, bit-serial search and marking
// depends on bba_pkg

module bba_engine
	import bba_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	input  cmd_t            cmd,
	input  logic [CntW-1:0] total,
	input  fit_t            fit,
	output logic            res_valid,
	input  logic            res_ready,
	output logic            res_ok,
	output logic [IdxW-1:0] res_start
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_MOD   = 7'b0000010,
		ST_RD    = 7'b0000100,
		ST_SCAN  = 7'b0001000,
		ST_MARK  = 7'b0010000,
		ST_MWR   = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t state_q;
	// written-word flags; unwritten words read all used
	logic [NumWords-1:0] wvalid_q;
	logic [WordBits-1:0] mem_q [NumWords];
	logic [WordBits-1:0] rd_q;
	logic [WordAw-1:0] raddr;
	logic ren;
	logic [WordBits-1:0] wdata;
	logic [WordAw-1:0] waddr;
	logic wen;

	cmd_t cmd_q;
	logic [CntW-1:0] ptr_q;
	logic [CntW-1:0] it_q;
	logic [CntW-1:0] pos_q;
	logic [CntW-1:0] run_st_q, run_len_q, pick_st_q, pick_len_q;
	logic have_q;
	logic [CntW-1:0] mk_q, mk_left_q;
	logic mark_used_q;
	logic ok_q;
	logic [IdxW-1:0] got_q;
	logic [3:0] msh_q;

	always_ff @(posedge clk) begin
		if (wen) mem_q[waddr] <= wdata;
		if (ren) rd_q <= wvalid_q[raddr] ? mem_q[raddr] : '1;
	end

	logic cur_used;
	logic [CntW-1:0] nxt;
	logic [CntW:0] nrl;
	logic better;
	logic [2*CntW-1:0] msub;
	logic [CntW-1:0] mrem;
	logic [CntW-1:0] moff;
	logic cur_fits;
	logic [CntW-1:0] fin_st;

	assign cur_used = rd_q[pos_q[BitAw-1:0]];
	assign nrl = {1'b0, run_len_q} + 1'b1;
	assign nxt = (pos_q + 1'b1 == total) ? '0 : pos_q + 1'b1;
	assign better = (fit == FIT_BEST) ? (run_len_q < pick_len_q) : (run_len_q > pick_len_q);
	// restoring remainder of the next-fit pointer, one shifted subtract per cycle
	assign msub = {{CntW{1'b0}}, total} << msh_q;
	assign mrem = ({{CntW{1'b0}}, pos_q} >= msub) ? pos_q - msub[CntW-1:0] : pos_q;
	assign moff = {{(CntW-BitAw){1'b0}}, mk_q[BitAw-1:0]};
	assign cur_fits = (run_len_q >= cmd_q.len) && (run_len_q != '0);
	assign fin_st = (cur_fits && (!have_q || better)) ? run_st_q : pick_st_q;

	always_comb begin
		ren = 1'b0;
		raddr = pos_q[IdxW-1:BitAw];
		wen = 1'b0;
		waddr = mk_q[IdxW-1:BitAw];
		wdata = rd_q;
		for (int b = 0; b < WordBits; b++) begin
			if (CntW'(b) >= moff && CntW'(b) - moff < mk_left_q)
				wdata[b] = mark_used_q;
		end
		unique case (state_q)
			ST_RD: ren = 1'b1;
			ST_MARK: begin
				ren = 1'b1;
				raddr = mk_q[IdxW-1:BitAw];
			end
			ST_MWR: wen = 1'b1;
			default: ;
		endcase
	end

	assign cmd_ready = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res_ok = ok_q;
	assign res_start = got_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wvalid_q <= '0;
			ptr_q <= '0;
			ok_q <= 1'b0;
			got_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (cmd_valid) begin
					cmd_q <= cmd;
					ok_q <= 1'b0;
					got_q <= '0;
					run_len_q <= '0;
					run_st_q <= '0;
					pick_len_q <= '0;
					pick_st_q <= '0;
					have_q <= 1'b0;
					it_q <= '0;
					if (cmd.bad) state_q <= ST_DONE;
					else if (cmd.action == ACT_ALLOC) begin
						pos_q <= (fit == FIT_NEXT) ? ptr_q : '0;
						msh_q <= 4'(IdxW);
						state_q <= (fit == FIT_NEXT) ? ST_MOD : ST_RD;
					end else begin
						mk_q <= {1'b0, cmd.start};
						mk_left_q <= cmd.len;
						mark_used_q <= (cmd.action == ACT_RESERVE);
						pos_q <= {1'b0, cmd.start};
						state_q <= ST_MARK;
						ok_q <= 1'b1;
					end
				end
				ST_MOD: begin
					pos_q <= mrem;
					if (msh_q == '0) state_q <= ST_RD;
					else msh_q <= msh_q - 1'b1;
				end
				ST_RD: state_q <= ST_SCAN;
				ST_SCAN: begin
					// one block per cycle; re-read when the word changes
					if (fit == FIT_FIRST || fit == FIT_NEXT) begin
						if (!cur_used) begin
							if (run_len_q == '0 || pos_q == '0) run_st_q <= pos_q;
							if (((pos_q == '0) ? CntW'(1) : nrl[CntW-1:0]) >= cmd_q.len) begin
								ok_q <= 1'b1;
								got_q <= (run_len_q == '0 || pos_q == '0) ? pos_q[IdxW-1:0]
								                                         : run_st_q[IdxW-1:0];
							end
							run_len_q <= (pos_q == '0) ? CntW'(1) : nrl[CntW-1:0];
						end else run_len_q <= '0;
						if (!cur_used && (((pos_q == '0) ? CntW'(1) : nrl[CntW-1:0]) >= cmd_q.len)) begin
							mk_q <= (run_len_q == '0 || pos_q == '0) ? pos_q : run_st_q;
							pos_q <= (run_len_q == '0 || pos_q == '0) ? pos_q : run_st_q;
							mk_left_q <= cmd_q.len;
							mark_used_q <= 1'b1;
							if (fit == FIT_NEXT)
								ptr_q <= ((run_len_q == '0 || pos_q == '0) ? pos_q : run_st_q)
								         + cmd_q.len;
							state_q <= ST_MARK;
						end else if (it_q + 1'b1 == total) state_q <= ST_DONE;
						else begin
							it_q <= it_q + 1'b1;
							pos_q <= nxt;
							state_q <= (nxt[BitAw-1:0] == '0) ? ST_RD : ST_SCAN;
						end
					end else begin
						if (!cur_used && it_q != total) begin
							if (run_len_q == '0) run_st_q <= pos_q;
							run_len_q <= nrl[CntW-1:0];
						end else begin
							if (cur_fits && (!have_q || better)) begin
								have_q <= 1'b1;
								pick_st_q <= run_st_q;
								pick_len_q <= run_len_q;
							end
							run_len_q <= '0;
						end
						if (it_q == total) begin
							if (have_q || cur_fits) begin
								ok_q <= 1'b1;
								got_q <= fin_st[IdxW-1:0];
								mk_q <= fin_st;
								pos_q <= fin_st;
								mk_left_q <= cmd_q.len;
								mark_used_q <= 1'b1;
								state_q <= ST_MARK;
							end else state_q <= ST_DONE;
						end else begin
							it_q <= it_q + 1'b1;
							pos_q <= pos_q + 1'b1;
							state_q <= ((pos_q[BitAw-1:0] == {BitAw{1'b1}}) && (it_q + 1'b1 != total))
							           ? ST_RD : ST_SCAN;
						end
					end
				end
				// read the word to patch
				ST_MARK: state_q <= ST_MWR;
				ST_MWR: begin
					wvalid_q[mk_q[IdxW-1:BitAw]] <= 1'b1;
					if (mk_left_q <= CntW'(WordBits) - moff)
						state_q <= ST_DONE;
					else begin
						mk_left_q <= mk_left_q - (CntW'(WordBits) - moff);
						mk_q <= {mk_q[CntW-1:BitAw] + 1'b1, {BitAw{1'b0}}};
						state_q <= ST_MARK;
					end
				end
				ST_DONE: if (res_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> res_valid) else $error("result dropped");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ok) |-> (res_start == '0)) else $error("start on failure");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !cmd_ready) else $error("ready while busy");
`endif

endmodule
